// ----- hdl/packet_delay_jitter_queue_defines.svh -----
// ----------------------------------------------------------------------------
// packet_delay_jitter_queue_defines.svh
// Assertion macros used by the checker file of the delay queue.
// ----------------------------------------------------------------------------
`ifndef PACKET_DELAY_JITTER_QUEUE_DEFINES_SVH
`define PACKET_DELAY_JITTER_QUEUE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PDJQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PDJQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pdjq_pkg.sv -----
// ----------------------------------------------------------------------------
// pdjq_pkg
// Shared types, widths and codes of the packet delay jitter queue.
// ----------------------------------------------------------------------------
package pdjq_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TAG_BITS_DEF    = 16;

    // Field widths
    localparam int TAG_FIELD_W = 16;
    localparam int RND_W       = 15;
    localparam int TIME_W      = 32;
    localparam int DELAY_W     = 14;
    localparam int JIT_W       = 11;
    localparam int FLUSH_W     = 7;
    localparam int PEND_W      = 7;
    localparam int KIND_W      = 2;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 24;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_ADDR_W-1:0] REG_DELAY    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_JITTER   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DLY_IN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DLY_OUT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FLUSH    = 3'd4;

    // Register reset values
    localparam logic [DELAY_W-1:0] DELAY_RST   = 14'd50;
    localparam logic [JIT_W-1:0]   JITTER_RST  = 11'd0;
    localparam logic               DLY_IN_RST  = 1'b1;
    localparam logic               DLY_OUT_RST = 1'b1;
    localparam logic [FLUSH_W-1:0] FLUSH_RST   = 7'd16;

    // Request and send kinds
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    localparam logic [KIND_W-1:0] KIND_PASS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DUE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_WRITE,
        ST_RD,
        ST_CHK,
        ST_LAST,
        ST_PASS
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic div_start;
        logic write;
        logic load_flush;
        logic pop;
        logic emit;
        logic emit_pass;
        logic emit_last;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic selected;
        logic jitter_nz;
        logic div_busy;
        logic fills;
        logic due;
        logic held_valid;
        logic slot_free;
    } status_t;

endpackage

// ----- hdl/packet_delay_jitter_queue.sv -----
// An undelayed arrival is captured, judged and then offered on the output;
// a buffered arrival is written to the queue, with jitter after the 15-step remainder unit.
// A tick walks the queue head, one queue memory read per released entry; an arrival that
// fills the queue forces entries out in the same kind of walk.
// Items are processed one at a time; a waiting result does not block the next transfer.
// Reset clears pointers, fill count and output valid, loads setting defaults; no memory sweep.
// ----------------------------------------------------------------------------
// packet_delay_jitter_queue
// Delay queue of a network impairment emulator: pass, buffer, flush and release.
// ----------------------------------------------------------------------------
module packet_delay_jitter_queue
#(
    parameter int QUEUE_DEPTH = pdjq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = pdjq_pkg::TAG_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration
    input  logic                            cfg_we,
    input  logic [pdjq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pdjq_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // packet_tag[15:0], is_outbound[16], random_value[31:17], now_ms[63:32]
    input  logic [pdjq_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic                            s_tuser,
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_tag[15:0], pending[22:16], zero pad[23]
    output logic [pdjq_pkg::OUT_DATA_W-1:0] m_tdata,
    // send_kind[1:0]
    output logic [pdjq_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast
);

    pdjq_pkg::cmd_t    cmd;
    pdjq_pkg::status_t st;

    pdjq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pdjq_dp
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/pdjq_div.sv -----
// ----------------------------------------------------------------------------
// pdjq_div
// Restoring remainder unit: one quotient bit per cycle for the jitter modulo.
// ----------------------------------------------------------------------------
module pdjq_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pdjq_pkg::RND_W-1:0] dividend,
    input  logic [pdjq_pkg::JIT_W-1:0] divisor,
    output logic                       busy,
    output logic [pdjq_pkg::JIT_W-1:0] rem
);

    localparam int CNT_W = $clog2(pdjq_pkg::RND_W + 1);

    logic                       busy_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [pdjq_pkg::RND_W-1:0] dvd_reg;
    logic [pdjq_pkg::JIT_W-1:0] rem_reg;
    logic [pdjq_pkg::JIT_W:0]   rem_sh;
    logic                       ge;

    // Shift in the next dividend bit and try the subtract
    assign rem_sh = {rem_reg, dvd_reg[pdjq_pkg::RND_W-1]};
    assign ge     = (rem_sh >= {1'b0, divisor});

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(pdjq_pkg::RND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Partial remainder and dividend shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[pdjq_pkg::RND_W-2:0], 1'b0};
            rem_reg <= ge ? pdjq_pkg::JIT_W'(rem_sh - {1'b0, divisor})
                          : rem_sh[pdjq_pkg::JIT_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ----- hdl/pdjq_dp.sv -----
// ----------------------------------------------------------------------------
// pdjq_dp
// Datapath: settings, item capture, queue memory, pointers, hold and output.
// ----------------------------------------------------------------------------
module pdjq_dp
#(
    parameter int QUEUE_DEPTH = pdjq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = pdjq_pkg::TAG_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  pdjq_pkg::cmd_t                  cmd,
    output pdjq_pkg::status_t               st,
    input  logic                            cfg_we,
    input  logic [pdjq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pdjq_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [pdjq_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [pdjq_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [pdjq_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast
);

    localparam int TAG_W = (TAG_BITS < pdjq_pkg::TAG_FIELD_W) ? TAG_BITS
                                                               : pdjq_pkg::TAG_FIELD_W;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Settings
    logic [pdjq_pkg::DELAY_W-1:0] delay_reg;
    logic [pdjq_pkg::JIT_W-1:0]   jitter_reg;
    logic                         dly_in_reg;
    logic                         dly_out_reg;
    logic [pdjq_pkg::FLUSH_W-1:0] flush_reg;

    // Captured item
    logic                         req_reg;
    logic [TAG_W-1:0]             tag_in_reg;
    logic                         outb_reg;
    logic [pdjq_pkg::RND_W-1:0]   rnd_reg;
    logic [pdjq_pkg::TIME_W-1:0]  now_reg;

    // Queue
    logic [TAG_W-1:0]             tag_mem [QUEUE_DEPTH];
    logic [pdjq_pkg::TIME_W-1:0]  rel_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]             rd_tag_reg;
    logic [pdjq_pkg::TIME_W-1:0]  rd_rel_reg;
    logic [PTR_W-1:0]             rd_ptr_reg;
    logic [PTR_W-1:0]             wr_ptr_reg;
    logic [CNT_W-1:0]             count_reg;

    // Flush run and held result
    logic                         flush_mode_reg;
    logic [pdjq_pkg::FLUSH_W-1:0] flush_left_reg;
    logic                         held_valid_reg;
    logic [TAG_W-1:0]             held_tag_reg;
    logic [pdjq_pkg::PEND_W-1:0]  held_pend_reg;

    // Output register
    logic                         m_tvalid_reg;
    logic [pdjq_pkg::TAG_FIELD_W-1:0] out_tag_reg;
    logic [pdjq_pkg::PEND_W-1:0]  out_pend_reg;
    logic [pdjq_pkg::KIND_W-1:0]  out_kind_reg;
    logic                         out_last_reg;

    logic                         div_busy;
    logic [pdjq_pkg::JIT_W-1:0]   div_rem;
    logic [pdjq_pkg::JIT_W-1:0]   jit_term;
    logic [pdjq_pkg::TIME_W-1:0]  rel_time;
    logic                         fifo_nz;

    // Jitter remainder
    pdjq_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rnd_reg),
        .divisor  (jitter_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    // Settings writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg   <= pdjq_pkg::DELAY_RST;
            jitter_reg  <= pdjq_pkg::JITTER_RST;
            dly_in_reg  <= pdjq_pkg::DLY_IN_RST;
            dly_out_reg <= pdjq_pkg::DLY_OUT_RST;
            flush_reg   <= pdjq_pkg::FLUSH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pdjq_pkg::REG_DELAY:   delay_reg   <= cfg_data[pdjq_pkg::DELAY_W-1:0];
                pdjq_pkg::REG_JITTER:  jitter_reg  <= cfg_data[pdjq_pkg::JIT_W-1:0];
                pdjq_pkg::REG_DLY_IN:  dly_in_reg  <= cfg_data[0];
                pdjq_pkg::REG_DLY_OUT: dly_out_reg <= cfg_data[0];
                pdjq_pkg::REG_FLUSH:   flush_reg   <= cfg_data[pdjq_pkg::FLUSH_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg    <= s_tuser;
            tag_in_reg <= s_tdata[TAG_W-1:0];
            outb_reg   <= s_tdata[16];
            rnd_reg    <= s_tdata[31:17];
            now_reg    <= s_tdata[63:32];
        end
    end

    // Release time, wraps at 32 bits
    assign jit_term = (jitter_reg != '0) ? div_rem : '0;
    assign rel_time = now_reg + pdjq_pkg::TIME_W'(delay_reg)
                              + pdjq_pkg::TIME_W'(jit_term);

    // Queue memory write and registered read at the head
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            tag_mem[wr_ptr_reg] <= tag_in_reg;
            rel_mem[wr_ptr_reg] <= rel_time;
        end
        rd_tag_reg <= tag_mem[rd_ptr_reg];
        rd_rel_reg <= rel_mem[rd_ptr_reg];
    end

    // Pointers, fill count and flush run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
            flush_mode_reg <= 1'b0;
            flush_left_reg <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                flush_mode_reg <= 1'b0;
            end
            if (cmd.write)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
                count_reg  <= count_reg + 1'b1;
            end
            if (cmd.load_flush)
            begin
                flush_mode_reg <= 1'b1;
                flush_left_reg <= (flush_reg == '0) ? pdjq_pkg::FLUSH_W'(1) : flush_reg;
            end
            if (cmd.pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
                count_reg  <= count_reg - 1'b1;
                if (flush_mode_reg)
                begin
                    flush_left_reg <= flush_left_reg - 1'b1;
                end
            end
            if (cmd.pop)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (cmd.emit)
            begin
                held_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the popped entry until the next one is judged
    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            held_tag_reg  <= rd_tag_reg;
            held_pend_reg <= pdjq_pkg::PEND_W'(count_reg - 1'b1);
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cmd.emit_pass)
            begin
                out_tag_reg  <= pdjq_pkg::TAG_FIELD_W'(tag_in_reg);
                out_pend_reg <= pdjq_pkg::PEND_W'(count_reg);
                out_kind_reg <= pdjq_pkg::KIND_PASS;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_tag_reg  <= pdjq_pkg::TAG_FIELD_W'(held_tag_reg);
                out_pend_reg <= held_pend_reg;
                out_kind_reg <= flush_mode_reg ? pdjq_pkg::KIND_FLUSH : pdjq_pkg::KIND_DUE;
                out_last_reg <= cmd.emit_last;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_pend_reg, out_tag_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller
    assign fifo_nz       = (count_reg != '0);
    assign st.is_tick    = (req_reg == pdjq_pkg::REQ_TICK);
    assign st.selected   = outb_reg ? dly_out_reg : dly_in_reg;
    assign st.jitter_nz  = (jitter_reg != '0);
    assign st.div_busy   = div_busy;
    assign st.fills      = (count_reg == CNT_W'(QUEUE_DEPTH - 1));
    assign st.due        = fifo_nz && (flush_mode_reg ? (flush_left_reg != '0)
                                                      : (now_reg > rd_rel_reg));
    assign st.held_valid = held_valid_reg;
    assign st.slot_free  = !m_tvalid_reg || m_tready;

endmodule

// ----- hdl/pdjq_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdjq_ctrl
// Controller: sequences capture, jitter modulo, queue write and release walk.
// ----------------------------------------------------------------------------
module pdjq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pdjq_pkg::status_t st,
    output pdjq_pkg::cmd_t    cmd
);

    pdjq_pkg::state_t state_reg;
    pdjq_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdjq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            pdjq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = pdjq_pkg::ST_DECIDE;
                end
            end
            pdjq_pkg::ST_DECIDE:
            begin
                if (st.is_tick)
                begin
                    state_next = pdjq_pkg::ST_RD;
                end
                else if (!st.selected)
                begin
                    state_next = pdjq_pkg::ST_PASS;
                end
                else if (st.jitter_nz)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = pdjq_pkg::ST_DIV;
                end
                else
                begin
                    state_next = pdjq_pkg::ST_WRITE;
                end
            end
            pdjq_pkg::ST_DIV:
            begin
                if (!st.div_busy)
                begin
                    state_next = pdjq_pkg::ST_WRITE;
                end
            end
            pdjq_pkg::ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (st.fills)
                begin
                    cmd.load_flush = 1'b1;
                    state_next     = pdjq_pkg::ST_RD;
                end
                else
                begin
                    state_next = pdjq_pkg::ST_IDLE;
                end
            end
            pdjq_pkg::ST_RD:
            begin
                state_next = pdjq_pkg::ST_CHK;
            end
            pdjq_pkg::ST_CHK:
            begin
                // A due head means the held result is not the last one
                if (st.due)
                begin
                    if (!st.held_valid)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = pdjq_pkg::ST_RD;
                    end
                    else if (st.slot_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.pop    = 1'b1;
                        state_next = pdjq_pkg::ST_RD;
                    end
                end
                else if (st.held_valid)
                begin
                    state_next = pdjq_pkg::ST_LAST;
                end
                else
                begin
                    state_next = pdjq_pkg::ST_IDLE;
                end
            end
            pdjq_pkg::ST_LAST:
            begin
                if (st.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = pdjq_pkg::ST_IDLE;
                end
            end
            pdjq_pkg::ST_PASS:
            begin
                if (st.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_pass = 1'b1;
                    state_next    = pdjq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdjq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/pdjq_checker.sv -----
// ----------------------------------------------------------------------------
// pdjq_checker
// Port-level checks of the delay queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_delay_jitter_queue_defines.svh"

module pdjq_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pdjq_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [pdjq_pkg::KIND_W-1:0]     m_tuser,
    input logic                            m_tlast
);

    // Stalled result holds its payload
    `PDJQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // Only defined send kinds leave the block
    `PDJQ_ASSERT_SAME(a_kind_ok, m_tvalid, m_tuser == pdjq_pkg::KIND_PASS || m_tuser == pdjq_pkg::KIND_DUE || m_tuser == pdjq_pkg::KIND_FLUSH, "undefined send kind")

    // An undelayed packet is always the only result of its item
    `PDJQ_ASSERT_SAME(a_pass_last, m_tvalid && m_tuser == pdjq_pkg::KIND_PASS, m_tlast, "pass result without last")

    // One item at a time: no transfer right after a transfer
    `PDJQ_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while busy")

endmodule

bind packet_delay_jitter_queue pdjq_checker u_pdjq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet delay jitter queue. A behavioral copy of
// the queue predicts every send; a checker matches each output transfer
// against the oldest prediction. Directed items come first, then random
// traffic over several register settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;

    import pdjq_pkg::*;

    localparam int QDEPTH        = QUEUE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 5000;

    typedef struct {
        logic [15:0]       tag;
        logic [KIND_W-1:0] kind;
        logic [PEND_W-1:0] pend;
        logic              last;
    } send_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_DELAY;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = REQ_ARRIVAL;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    // Mirror of the register file
    logic [DELAY_W-1:0] dly_ms  = DELAY_RST;
    logic [JIT_W-1:0]   jit_ms  = JITTER_RST;
    logic               dly_in  = DLY_IN_RST;
    logic               dly_out = DLY_OUT_RST;
    logic [FLUSH_W-1:0] flush_n = FLUSH_RST;

    // Mirror of the delay FIFO
    logic [15:0]     held_tag[QDEPTH];
    logic [TIME_W-1:0] held_release[QDEPTH];
    int unsigned     rd_idx = 0;
    int unsigned     wr_idx = 0;
    int unsigned     held   = 0;

    send_t       awaited_sends[$];
    send_t       got_send;
    int          errors       = 0;
    int unsigned quiet_cycles = 0;
    int          sink_hold    = 0;
    int          stall_draw;
    bit          sender_calm  = 1'b0;
    bit          sink_calm    = 1'b0;
    logic [31:0] wall_ms      = '0;

    packet_delay_jitter_queue u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Pick an idle length: mostly none or short, a few long
    function automatic int pause_length(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Take the oldest held packet off the FIFO mirror
    function automatic send_t pop_held(logic [KIND_W-1:0] kind);
        send_t s;
        s.tag  = held_tag[rd_idx];
        rd_idx = (rd_idx + 1) % QDEPTH;
        held   = held - 1;
        s.kind = kind;
        s.pend = PEND_W'(held);
        s.last = 1'b0;
        return s;
    endfunction

    // Work out the sends caused by one accepted transfer
    function automatic void emulate_delay_queue(logic req, logic [15:0] tag, logic outb,
                                                logic [RND_W-1:0] rnd, logic [31:0] stamp);
        send_t       sends[$];
        send_t       s;
        logic [31:0] rel;
        int unsigned budget;
        bit          selected;
        if (req == REQ_ARRIVAL)
        begin
            selected = outb ? dly_out : dly_in;
            if (!selected)
            begin
                s.tag  = tag;
                s.kind = KIND_PASS;
                s.pend = PEND_W'(held);
                s.last = 1'b0;
                sends.push_back(s);
            end
            else
            begin
                rel = stamp + 32'(dly_ms);
                if (jit_ms != 0)
                    rel = rel + ({17'd0, rnd} % {21'd0, jit_ms});
                held_tag[wr_idx]     = tag;
                held_release[wr_idx] = rel;
                wr_idx = (wr_idx + 1) % QDEPTH;
                held   = held + 1;
                // Full queue: force out the oldest entries, zero count acts as one
                if (held >= QDEPTH)
                begin
                    budget = (flush_n == 0) ? 1 : flush_n;
                    while (budget > 0 && held > 0)
                    begin
                        sends.push_back(pop_held(KIND_FLUSH));
                        budget--;
                    end
                end
            end
        end
        else
        begin
            // Release while strictly past the release time of the head
            while (held > 0 && stamp > held_release[rd_idx])
                sends.push_back(pop_held(KIND_DUE));
        end
        if (sends.size() > 0)
            sends[sends.size() - 1].last = 1'b1;
        foreach (sends[i])
            awaited_sends.push_back(sends[i]);
    endfunction

    // Send one item on the input stream and predict its sends
    task automatic send_item(logic req, logic [15:0] tag, logic outb,
                             logic [RND_W-1:0] rnd, logic [31:0] stamp);
        int gap;
        gap = pause_length(sender_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {stamp, rnd, outb, tag};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        emulate_delay_queue(req, tag, outb, rnd, stamp);
    endtask

    // Drop valid, wait for every predicted send, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (awaited_sends.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five registers in back-to-back cycles while idle
    task automatic apply_settings(logic [DELAY_W-1:0] d, logic [JIT_W-1:0] j,
                                  logic din, logic dout, logic [FLUSH_W-1:0] fl);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_addr <= REG_DELAY;
        cfg_data <= CFG_DATA_W'(d);
        @(posedge clk);
        cfg_addr <= REG_JITTER;
        cfg_data <= CFG_DATA_W'(j);
        @(posedge clk);
        cfg_addr <= REG_DLY_IN;
        cfg_data <= CFG_DATA_W'(din);
        @(posedge clk);
        cfg_addr <= REG_DLY_OUT;
        cfg_data <= CFG_DATA_W'(dout);
        @(posedge clk);
        cfg_addr <= REG_FLUSH;
        cfg_data <= CFG_DATA_W'(fl);
        @(posedge clk);
        cfg_we   <= 1'b0;
        dly_ms  = d;
        jit_ms  = j;
        dly_in  = din;
        dly_out = dout;
        flush_n = fl;
    endtask

    // Tag, direction, random value and time at their extremes, nothing delayed
    task automatic test_pass_through();
        apply_settings(DELAY_RST, 11'd0, 1'b0, 1'b0, FLUSH_RST);
        send_item(REQ_ARRIVAL, 16'h0000, 1'b0, 15'h0000, 32'h0000_0000);
        send_item(REQ_ARRIVAL, 16'hFFFF, 1'b1, 15'h7FFF, 32'hFFFF_FFFF);
        send_item(REQ_ARRIVAL, 16'h5AA5, 1'b1, RND_W'($urandom_range(0, 32767)),
                  32'($urandom()));
    endtask

    // One direction delayed; release only once time is strictly past due
    task automatic test_release_strict();
        apply_settings(DELAY_RST, 11'd0, 1'b1, 1'b0, FLUSH_RST);
        send_item(REQ_ARRIVAL, 16'hA5A5, 1'b1, 15'h1234, 32'd1000);
        send_item(REQ_ARRIVAL, 16'h1234, 1'b0, 15'h7FFF, 32'd1000);
        send_item(REQ_TICK, 16'hFFFF, 1'b1, 15'h7FFF, 32'd1050);
        send_item(REQ_TICK, 16'h0000, 1'b0, 15'h0000, 32'd1051);
    endtask

    // Largest delay and jitter, out-of-order release times stall the head
    task automatic test_jitter_extremes();
        apply_settings(14'h3FFF, 11'h7FF, 1'b1, 1'b1, FLUSH_RST);
        send_item(REQ_ARRIVAL, 16'h0001, 1'b0, 15'h7FFF, 32'd0);
        send_item(REQ_ARRIVAL, 16'h0002, 1'b1, 15'h0000, 32'd0);
        send_item(REQ_ARRIVAL, 16'h0003, 1'b0, 15'd2046, 32'd0);
        send_item(REQ_TICK, 16'h0000, 1'b0, 15'h0000, 32'd16399);
        send_item(REQ_TICK, 16'h0000, 1'b0, 15'h0000, 32'hFFFF_FFFF);
        apply_settings(14'd0, 11'd1, 1'b1, 1'b1, FLUSH_RST);
        send_item(REQ_ARRIVAL, 16'h8001, 1'b1, 15'h7FFF, 32'd7);
        send_item(REQ_TICK, 16'h0000, 1'b0, 15'h0000, 32'd8);
    endtask

    // Release time wrapping past 2^32 and a tick on an empty queue
    task automatic test_time_wrap();
        apply_settings(14'd100, 11'd0, 1'b1, 1'b1, FLUSH_RST);
        send_item(REQ_TICK, 16'h0000, 1'b0, 15'h0000, 32'hFFFF_FFFF);
        send_item(REQ_ARRIVAL, 16'hC0DE, 1'b0, 15'h0000, 32'hFFFF_FFC0);
        send_item(REQ_TICK, 16'h0000, 1'b0, 15'h0000, 32'hFFFF_FFF0);
        send_item(REQ_ARRIVAL, 16'hBEEF, 1'b1, 15'h0000, 32'd10);
        send_item(REQ_TICK, 16'h0000, 1'b0, 15'h0000, 32'd5);
        send_item(REQ_TICK, 16'h0000, 1'b0, 15'h0000, 32'd111);
    endtask

    // Advance the emulated time and mix arrivals with ticks, a few wild times
    task automatic run_traffic(int n_items, int tick_pct, int unsigned span);
        logic [31:0] stamp;
        logic        req;
        for (int k = 0; k < n_items; k++)
        begin
            wall_ms = wall_ms + $urandom_range(0, span);
            req     = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_ARRIVAL;
            stamp   = wall_ms;
            if ($urandom_range(0, 99) < 5)
                stamp = $urandom();
            send_item(req, 16'($urandom()), 1'($urandom_range(0, 1)),
                      RND_W'($urandom_range(0, 32767)), stamp);
        end
    endtask

    // Random traffic over several settings, fill phases to force flushes
    task automatic test_random_traffic();
        sender_calm = 1'b0;
        sink_calm   = 1'b0;
        wall_ms     = 32'd5000;
        apply_settings(DELAY_RST, 11'd0, 1'b1, 1'b1, FLUSH_RST);
        run_traffic(40, 30, 20);
        apply_settings(14'd0, 11'h7FF, 1'b1, 1'b0, 7'd1);
        run_traffic(40, 35, 400);

        // Fill the queue: flush sixteen, then one, then more than held, then all
        sender_calm = 1'b1;
        sink_calm   = 1'b1;
        apply_settings(14'h3FFF, 11'd0, 1'b1, 1'b1, 7'd16);
        run_traffic(90, 3, 2);
        apply_settings(14'h3FFF, 11'd0, 1'b1, 1'b1, 7'd0);
        run_traffic(60, 3, 2);
        sender_calm = 1'b0;
        sink_calm   = 1'b0;
        apply_settings(14'h3FFF, 11'h7FF, 1'b1, 1'b1, 7'h7F);
        run_traffic(80, 2, 2);
        apply_settings(14'd15000, 11'd2000, 1'b1, 1'b1, 7'd64);
        run_traffic(80, 2, 2);

        // Drain, then run across the 32-bit time wrap
        apply_settings(14'd800, 11'd50, 1'b0, 1'b1, 7'd16);
        send_item(REQ_TICK, 16'h0000, 1'b0, 15'h0000, 32'hFFFF_FFFF);
        wall_ms = 32'hFFFF_E000;
        run_traffic(40, 30, 200);

        sink_calm = 1'b1;
        apply_settings(DELAY_W'($urandom_range(0, 16383)), JIT_W'($urandom_range(0, 2047)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       FLUSH_W'($urandom_range(0, 127)));
        run_traffic(40, 30, $urandom_range(1, 2000));
        sink_calm = 1'b0;
    endtask

    // Hold the output ready low for random stretches
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
        begin
            stall_draw = pause_length(sink_calm);
            m_tready  <= (stall_draw == 0);
            sink_hold <= (stall_draw > 0) ? stall_draw - 1 : 0;
        end
    end

    // Compare each output transfer with the oldest predicted send
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_sends.size() == 0)
            begin
                $error("unpredicted send: out_tag %h send_kind %0d", m_tdata[15:0], m_tuser);
                errors++;
            end
            else
            begin
                got_send = awaited_sends.pop_front();
                if (m_tdata[15:0] !== got_send.tag)
                begin
                    $error("out_tag: expected %h, actual %h", got_send.tag, m_tdata[15:0]);
                    errors++;
                end
                if (m_tuser !== got_send.kind)
                begin
                    $error("send_kind: expected %0d, actual %0d", got_send.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[22:16] !== got_send.pend)
                begin
                    $error("pending: expected %0d, actual %0d", got_send.pend, m_tdata[22:16]);
                    errors++;
                end
                if (m_tlast !== got_send.last)
                begin
                    $error("last: expected %0d, actual %0d", got_send.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("packet_delay_jitter_queue verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pass_through();
        test_release_strict();
        test_jitter_extremes();
        test_time_wrap();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("packet_delay_jitter_queue verification clean");
        else
            $display("packet_delay_jitter_queue verification failed");
        $finish;
    end

endmodule
